// ----- hdl/utf8d_pkg.sv -----
// Shared types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // Lead-byte classification masks and patterns
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;

    // Sequence lengths; zero means no sequence pending
    localparam logic [2:0] LEN_IDLE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // One decoded item's worth of work: rep_count replacements, then an
    // optional tail codepoint.
    typedef struct packed {
        logic [1:0]      rep_count;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
    } job_t;

endpackage

// ----- hdl/utf8d_front.sv -----
// Front end: accept bytes, track the pending sequence, classify into jobs.
module utf8d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_text,
    output logic              job_push,
    output utf8d_pkg::job_t   job
);

    logic [2:0] el_reg;
    logic [2:0] el_next;
    logic [1:0] hc_reg;
    logic [1:0] hc_next;
    logic [7:0] held0_reg;
    logic [7:0] held1_reg;
    logic [7:0] held2_reg;
    logic       wr_held0;
    logic       wr_held1;
    logic       wr_held2;
    logic [2:0] lead_len;
    logic       is_cont;
    logic [utf8d_pkg::CP_W-1:0] assembled;

    always_comb
    begin
        if ((data_byte & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::PAT_LEAD2)
        begin
            lead_len = utf8d_pkg::LEN_2;
        end
        else if ((data_byte & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::PAT_LEAD3)
        begin
            lead_len = utf8d_pkg::LEN_3;
        end
        else if ((data_byte & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::PAT_LEAD4)
        begin
            lead_len = utf8d_pkg::LEN_4;
        end
        else
        begin
            lead_len = utf8d_pkg::LEN_IDLE;
        end
    end

    assign is_cont = ((data_byte & utf8d_pkg::MASK_CONT) == utf8d_pkg::PAT_CONT);

    always_comb
    begin
        case (el_reg)
            utf8d_pkg::LEN_2:
                assembled = {10'd0, held0_reg[4:0], data_byte[5:0]};
            utf8d_pkg::LEN_3:
                assembled = {5'd0, held0_reg[3:0], held1_reg[5:0], data_byte[5:0]};
            default:
                assembled = {held0_reg[2:0], held1_reg[5:0], held2_reg[5:0],
                             data_byte[5:0]};
        endcase
    end

    always_comb
    begin
        job.rep_count = 2'd0;
        job.has_tail  = 1'b0;
        job.tail_cp   = {13'd0, data_byte};
        el_next       = el_reg;
        hc_next       = hc_reg;
        wr_held0      = 1'b0;
        wr_held1      = 1'b0;
        wr_held2      = 1'b0;
        if (end_of_text)
        begin
            // Flush: one replacement per held byte
            if (el_reg != utf8d_pkg::LEN_IDLE)
            begin
                job.rep_count = hc_reg;
            end
            el_next = utf8d_pkg::LEN_IDLE;
            hc_next = 2'd0;
        end
        else if (el_reg == utf8d_pkg::LEN_IDLE || !is_cont)
        begin
            // Drop a broken sequence, then decode the byte from idle
            if (el_reg != utf8d_pkg::LEN_IDLE)
            begin
                job.rep_count = hc_reg;
            end
            el_next = utf8d_pkg::LEN_IDLE;
            hc_next = 2'd0;
            if (!data_byte[7])
            begin
                job.has_tail = 1'b1;
            end
            else if (lead_len != utf8d_pkg::LEN_IDLE)
            begin
                wr_held0 = 1'b1;
                hc_next  = 2'd1;
                el_next  = lead_len;
            end
            else
            begin
                job.has_tail = 1'b1;
                job.tail_cp  = utf8d_pkg::REPL_CP;
            end
        end
        else if (({1'b0, hc_reg} + 3'd1) >= el_reg)
        begin
            // Sequence complete
            job.has_tail = 1'b1;
            job.tail_cp  = assembled;
            el_next      = utf8d_pkg::LEN_IDLE;
            hc_next      = 2'd0;
        end
        else
        begin
            case (hc_reg)
                2'd1:    wr_held1 = 1'b1;
                2'd2:    wr_held2 = 1'b1;
                default: wr_held0 = 1'b0;
            endcase
            hc_next = hc_reg + 2'd1;
        end
    end

    assign job_push = accept && (job.rep_count != 2'd0 || job.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            el_reg <= utf8d_pkg::LEN_IDLE;
            hc_reg <= 2'd0;
        end
        else if (accept)
        begin
            el_reg <= el_next;
            hc_reg <= hc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_held0)
        begin
            held0_reg <= data_byte;
        end
        if (accept && wr_held1)
        begin
            held1_reg <= data_byte;
        end
        if (accept && wr_held2)
        begin
            held2_reg <= data_byte;
        end
    end

endmodule

// ----- hdl/utf8d_queue.sv -----
// Job queue between the front end and the result expander.
module utf8d_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utf8d_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output utf8d_pkg::job_t   head_job,
    output logic              empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::job_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/utf8d_back.sv -----
// Back end: expand each job into result items through an output register.
module utf8d_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  utf8d_pkg::job_t              job,
    input  logic                         job_empty,
    output logic                         job_pop,
    output logic [utf8d_pkg::CP_W-1:0]   codepoint,
    output logic                         last_in_run,
    output logic                         empty,
    input  logic                         pop
);

    logic [1:0]                 sub_reg;
    logic [1:0]                 sub_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic [utf8d_pkg::CP_W-1:0] cp_reg;
    logic                       last_reg;
    logic                       load;
    logic [2:0]                 total;
    logic                       is_last;
    logic [utf8d_pkg::CP_W-1:0] cp_sel;

    assign total   = {1'b0, job.rep_count} + {2'b00, job.has_tail};
    assign is_last = (({1'b0, sub_reg} + 3'd1) == total);
    assign cp_sel  = (sub_reg < job.rep_count) ? utf8d_pkg::REPL_CP : job.tail_cp;
    assign load    = !job_empty && (!valid_reg || pop);
    assign job_pop = load && is_last;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = is_last ? 2'd0 : sub_reg + 2'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= cp_sel;
            last_reg <= is_last;
        end
    end

    assign codepoint   = cp_reg;
    assign last_in_run = last_reg;
    assign empty       = !valid_reg;

endmodule

// ----- hdl/utf8_stream_decoder_core.sv -----
// Top level of the streaming UTF-8 decoder.
// The decoder takes one byte per cycle and gives 21-bit codepoints. ASCII
// bytes pass through, lead bytes of 2, 3 and 4 byte forms are held with
// their continuations until the sequence completes, and every rejected byte
// (stray continuation, invalid lead, a held byte of a broken sequence, or
// one flushed by end_of_text) comes out as 0xFFFD. No overlong or surrogate
// check is made. The input side accepts one byte every cycle; the front end
// classifies it in that cycle and posts a job to a queue of QUEUE_DEPTH
// entries. The back end drains one result item per cycle from the queue
// through its output register, so a byte that causes k results (up to four)
// holds the result side until all k have drained, and the input stalls
// (full high) only once the queue has filled behind such bursts or behind a
// stalled consumer. A byte's results pass through its queue entry and then
// the output register; last_in_run marks the final result of each byte.
module utf8_stream_decoder_core
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] codepoint,
    output logic        last_in_run
);

    logic            accept;
    logic            job_push;
    utf8d_pkg::job_t front_job;
    utf8d_pkg::job_t head_job;
    logic            q_empty;
    logic            q_pop;

    // Advance the front end only on an accepted item
    assign accept = push && !full;

    utf8d_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .job_push    (job_push),
        .job         (front_job)
    );

    // Decouple classification from result expansion
    utf8d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .full     (full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    utf8d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (head_job),
        .job_empty   (q_empty),
        .job_pop     (q_pop),
        .codepoint   (codepoint),
        .last_in_run (last_in_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ----- hdl/utf8d_checker.sv -----
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
module utf8d_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [20:0] codepoint,
    input  logic        last_in_run
);

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(codepoint) && $stable(last_in_run)))
        else $error("result item changed while waiting");

    // Only replacements precede the final result of a byte
    a_nonlast_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_in_run) |-> (codepoint == utf8d_pkg::REPL_CP))
        else $error("non-final result is not a replacement");

    // A full queue means the output register is occupied
    a_full_implies_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("input stalled with no result waiting");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .codepoint   (codepoint),
    .last_in_run (last_in_run)
);

// ----- bench/tb.sv -----
// Self-checking testbench of the streaming UTF-8 decoder core.
`timescale 1ns / 100ps

module tb;

    // One decoded codepoint as it is expected on the result ports
    typedef struct {
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic                       last;
    } cp_item_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       push        = 1'b0;
    logic [7:0]                 data_byte   = 8'h00;
    logic                       end_of_text = 1'b0;
    logic                       pop         = 1'b0;
    logic                       full;
    logic                       empty;
    logic [utf8d_pkg::CP_W-1:0] codepoint;
    logic                       last_in_run;

    // Codepoints still owed by the decoder, oldest first
    cp_item_t        pending_cps[$];
    // Codepoints caused by the byte being decoded right now
    cp_item_t        run_cps[$];

    // Decoder state as the bench tracks it
    logic [7:0]      stash[0:2];
    int unsigned     stash_n = 0;
    logic [2:0]      seq_len = utf8d_pkg::LEN_IDLE;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     bytes_sent    = 0;
    int unsigned     errors        = 0;

    utf8_stream_decoder_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .codepoint   (codepoint),
        .last_in_run (last_in_run)
    );

    always #10 clk = ~clk;

    // Hard stop: far beyond the slowest legal run of every item at its most
    // results behind the longest receiver stalls.
    initial
    begin
        #5_000_000;
        $display("** utf8_stream_decoder_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Failure bookkeeping: show the first ten, count the rest.
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Decoder prediction.
    // ------------------------------------------------------------------

    // Append one codepoint to the results of the current byte.
    function automatic void add_cp(input logic [utf8d_pkg::CP_W-1:0] cp);
        cp_item_t entry;
        entry.cp   = cp;
        entry.last = 1'b0;
        run_cps.insert(run_cps.size(), entry);
    endfunction

    // Reject every stashed byte with one replacement each, then go idle.
    function automatic void reject_stash();
        for (int unsigned i = 0; i < stash_n && i < 3; i++)
        begin
            add_cp(utf8d_pkg::REPL_CP);
        end
        stash_n = 0;
        seq_len = utf8d_pkg::LEN_IDLE;
    endfunction

    // Decode a byte with nothing pending: pass ASCII, open a sequence on a
    // valid lead, replace anything else.
    function automatic void open_seq(input logic [7:0] b);
        logic [2:0] len;
        len = utf8d_pkg::LEN_IDLE;
        if (!b[7])
        begin
            add_cp({13'd0, b});
            return;
        end
        if ((b & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::PAT_LEAD2)
        begin
            len = utf8d_pkg::LEN_2;
        end
        else if ((b & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::PAT_LEAD3)
        begin
            len = utf8d_pkg::LEN_3;
        end
        else if ((b & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::PAT_LEAD4)
        begin
            len = utf8d_pkg::LEN_4;
        end
        if (len == utf8d_pkg::LEN_IDLE)
        begin
            add_cp(utf8d_pkg::REPL_CP);
            return;
        end
        stash[0] = b;
        stash_n  = 1;
        seq_len  = len;
    endfunction

    // Advance the tracked state by one accepted item and queue what it causes.
    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [utf8d_pkg::CP_W-1:0] cp;
        run_cps.delete();
        if (eot)
        begin
            // Flush a partial sequence; an idle decoder gives nothing.
            if (seq_len != utf8d_pkg::LEN_IDLE)
            begin
                reject_stash();
            end
            stash_n = 0;
            seq_len = utf8d_pkg::LEN_IDLE;
        end
        else if (seq_len == utf8d_pkg::LEN_IDLE)
        begin
            open_seq(b);
        end
        else if ((b & utf8d_pkg::MASK_CONT) == utf8d_pkg::PAT_CONT)
        begin
            if (stash_n + 1 >= seq_len)
            begin
                // Sequence complete: no overlong or surrogate check.
                case (seq_len)
                    utf8d_pkg::LEN_2:
                        cp = {10'd0, stash[0][4:0], b[5:0]};
                    utf8d_pkg::LEN_3:
                        cp = {5'd0, stash[0][3:0], stash[1][5:0], b[5:0]};
                    default:
                        cp = {stash[0][2:0], stash[1][5:0], stash[2][5:0], b[5:0]};
                endcase
                add_cp(cp);
                stash_n = 0;
                seq_len = utf8d_pkg::LEN_IDLE;
            end
            else if (stash_n < 3)
            begin
                stash[stash_n] = b;
                stash_n++;
            end
            else
            begin
                stash_n = 0;
                seq_len = utf8d_pkg::LEN_IDLE;
            end
        end
        else
        begin
            // Broken sequence: replace the held bytes, decode the breaker afresh.
            reject_stash();
            open_seq(b);
        end
        if (run_cps.size() > 0)
        begin
            run_cps[run_cps.size()-1].last = 1'b1;
        end
        foreach (run_cps[i])
        begin
            pending_cps.insert(pending_cps.size(), run_cps[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: idle at random, then hold the item until full is low at an edge.
    // push stays high on return so back-to-back items need no gap.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        end_of_text <= eot;
        do
        begin
            @(posedge clk);
        end
        while (full);
        decode_byte(b, eot);
        if (!eot)
        begin
            bytes_sent++;
        end
    endtask

    // Receiver: pop at random according to the current idling rate.
    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result check: compare every accepted item with the oldest expectation.
    always @(posedge clk)
    begin
        cp_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_cps.size() == 0)
            begin
                note_failure($sformatf("unexpected result codepoint=%06h last=%b",
                                       codepoint, last_in_run));
            end
            else
            begin
                want = pending_cps.pop_front();
                if (codepoint !== want.cp)
                begin
                    note_failure($sformatf("codepoint: expected %06h, got %06h",
                                           want.cp, codepoint));
                end
                if (last_in_run !== want.last)
                begin
                    note_failure($sformatf("last_in_run: expected %b, got %b (cp %06h)",
                                           want.last, last_in_run, want.cp));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // ASCII extremes, zero byte included.
    task automatic test_ascii();
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
    endtask

    // Smallest and largest value of the 2-byte form, largest of the 3- and 4-byte forms.
    task automatic test_sequences();
        push_byte(8'hC0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
    endtask

    // Stray continuation and invalid leads.
    task automatic test_rejects();
        push_byte(8'h80, 1'b0);
        push_byte(8'hF8, 1'b0);
        push_byte(8'hFF, 1'b0);
    endtask

    // A 4-byte form broken by a new lead after three held bytes, then that
    // lead broken by a zero byte.
    task automatic test_broken();
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h00, 1'b0);
    endtask

    // End of text with a partial sequence, then with nothing pending; the
    // data byte rides along and must be ignored.
    task automatic test_end_of_text();
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h41, 1'b1);
        push_byte(8'hC3, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed characters with random payload,
    // the rest truncated forms, rejects, end-of-text and raw noise.
    // ------------------------------------------------------------------
    task automatic test_random(input int unsigned goal);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        int unsigned conts;
        stop_at = bytes_sent + goal;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = $urandom_range(1, 4);
                // Truncate a fifth of the multibyte forms; the next unit breaks them.
                conts = len - 1;
                if (len > 1 && pick >= 56)
                begin
                    conts = $urandom_range(0, len - 2);
                end
                case (len)
                    1:
                        push_byte(8'($urandom_range(0, 127)), 1'b0);
                    2:
                        push_byte(utf8d_pkg::PAT_LEAD2 | 8'($urandom_range(0, 31)), 1'b0);
                    3:
                        push_byte(utf8d_pkg::PAT_LEAD3 | 8'($urandom_range(0, 15)), 1'b0);
                    default:
                        push_byte(utf8d_pkg::PAT_LEAD4 | 8'($urandom_range(0, 7)), 1'b0);
                endcase
                repeat (conts)
                begin
                    push_byte(utf8d_pkg::PAT_CONT | 8'($urandom_range(0, 63)), 1'b0);
                end
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_byte(utf8d_pkg::PAT_CONT | 8'($urandom_range(0, 63)), 1'b0);
                end
                else
                begin
                    push_byte(utf8d_pkg::MASK_LEAD4 | 8'($urandom_range(0, 7)), 1'b0);
                end
            end
            else if (pick < 90)
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned waited;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles rarely, receiver often.
        send_idle_pct = 13;
        recv_idle_pct = 54;
        test_ascii();
        test_sequences();
        test_rejects();
        test_broken();
        test_end_of_text();
        test_random(60);

        // Swap the pressure: receiver fast, sender slow.
        send_idle_pct = 54;
        recv_idle_pct = 13;
        test_random(60);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(60);

        // Drop push and drain whatever is still owed.
        push <= 1'b0;
        waited = 0;
        while (pending_cps.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_cps.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_cps.size()));
        end

        if (errors == 0)
        begin
            $display("** utf8_stream_decoder_core: PASSED **");
        end
        else
        begin
            $display("** utf8_stream_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule
